/* rtl/core/dtoi_pkg.sv */
// Types and constants shared by the decimal text to int32 converter.
// No dependencies.
`default_nettype none

package dtoi_pkg;

  localparam int unsigned CodeW = 16;
  localparam int unsigned ValW  = 32;
  localparam int unsigned AccW  = 36;

  localparam logic [CodeW-1:0] CH_ZERO  = 16'd48;
  localparam logic [CodeW-1:0] CH_NINE  = 16'd57;
  localparam logic [CodeW-1:0] CH_MINUS = 16'd45;

  localparam logic [AccW-1:0] POS_LIMIT = 36'd2147483647;
  localparam logic [AccW-1:0] NEG_LIMIT = 36'd2147483648;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CHAR  = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_NO_DIGITS = 2'd3
  } status_e;

  typedef struct packed {
    logic       is_digit;
    logic       is_minus;
    logic [3:0] digit;
  } char_t;

  typedef struct packed {
    status_e              status;
    logic signed [ValW-1:0] value;
  } result_t;

endpackage

`default_nettype wire

/* rtl/core/dtoi_char_class.sv */
// Character classifier: digit, minus sign, digit value.
// Depends on dtoi_pkg.
`default_nettype none

module dtoi_char_class (
  input  logic [15:0]    code_i,
  output dtoi_pkg::char_t class_o
);
  import dtoi_pkg::*;

  logic [CodeW-1:0] diff;

  always_comb begin
    diff              = code_i - CH_ZERO;
    class_o.is_digit  = code_i inside {[CH_ZERO:CH_NINE]};
    class_o.is_minus  = (code_i == CH_MINUS);
    class_o.digit     = diff[3:0];
  end

endmodule

`default_nettype wire

/* rtl/core/dtoi_accum.sv */
// Accumulator: magnitude, sign and error flags, one character per step,
// with the result of the final character. Depends on dtoi_pkg.
`default_nettype none

module dtoi_accum (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  dtoi_pkg::char_t   class_i,
  input  logic              last_i,
  output dtoi_pkg::result_t result_o
);
  import dtoi_pkg::*;

  logic [ValW-1:0] mag_q, mag_d;
  logic            neg_q, neg_d;
  logic            first_q, first_d;
  logic            digit_q, digit_d;
  logic            bad_q, bad_d;
  logic            ovf_q, ovf_d;

  logic [AccW-1:0] mag_ext;
  logic [AccW-1:0] next_mag;
  logic [AccW-1:0] limit;

  always_comb begin
    mag_ext  = {{(AccW-ValW){1'b0}}, mag_q};
    next_mag = (mag_ext << 3) + (mag_ext << 1) + {{(AccW-4){1'b0}}, class_i.digit};
    limit    = neg_q ? NEG_LIMIT : POS_LIMIT;

    mag_d   = mag_q;
    neg_d   = neg_q;
    digit_d = digit_q;
    bad_d   = bad_q;
    ovf_d   = ovf_q;
    first_d = 1'b0;

    if (first_q && class_i.is_minus) begin
      neg_d = 1'b1;
    end else if (class_i.is_digit) begin
      digit_d = 1'b1;
      if (!ovf_q) begin
        if (next_mag > limit) begin
          ovf_d = 1'b1;
        end else begin
          mag_d = next_mag[ValW-1:0];
        end
      end
    end else begin
      bad_d = 1'b1;
    end

    result_o.value = '0;
    if (bad_d) begin
      result_o.status = ST_BAD_CHAR;
    end else if (ovf_d) begin
      result_o.status = ST_OVERFLOW;
    end else if (!digit_d) begin
      result_o.status = ST_NO_DIGITS;
    end else begin
      result_o.status = ST_OK;
      result_o.value  = neg_d ? ($signed(ValW'(0)) - $signed(mag_d)) : $signed(mag_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q   <= '0;
      neg_q   <= 1'b0;
      first_q <= 1'b1;
      digit_q <= 1'b0;
      bad_q   <= 1'b0;
      ovf_q   <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        mag_q   <= '0;
        neg_q   <= 1'b0;
        first_q <= 1'b1;
        digit_q <= 1'b0;
        bad_q   <= 1'b0;
        ovf_q   <= 1'b0;
      end else begin
        mag_q   <= mag_d;
        neg_q   <= neg_d;
        first_q <= first_d;
        digit_q <= digit_d;
        bad_q   <= bad_d;
        ovf_q   <= ovf_d;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/decimal_text_to_int32.sv */
// Top level: decimal text to signed 32-bit integer converter.
// Depends on dtoi_pkg, dtoi_char_class, dtoi_accum.
//
//   channel  | dir | tdata                    | tuser       | tlast
//   s_axis   | in  | [15:0] code_unit         | -           | last character
//   m_axis   | out | [31:0] value             | [1:0] status| -
//
// One word per cycle sustained, unless a last word waits on a full result register;
// input register, then one step of the accumulator (shift-add by ten, add, compare)
// into the result register, which holds the result until it is taken.
// Reset clears all flags and the magnitude; the first character may be a minus.
// Only a last word waits on a full result register; other words never stall.
`default_nettype none

module decimal_text_to_int32 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] code_unit
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] value
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);
  import dtoi_pkg::*;

  logic             in_valid_q;
  logic [CodeW-1:0] in_code_q;
  logic             in_last_q;
  logic             out_valid_q;
  result_t          out_res_q;

  logic    out_free;
  logic    step;
  logic    res_load;
  char_t   cls;
  result_t res;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign step            = in_valid_q && (!in_last_q || out_free);
  assign res_load        = step && in_last_q;
  assign s_axis_tready_o = !in_valid_q || step;

  dtoi_char_class u_class (
    .code_i  (in_code_q),
    .class_o (cls)
  );

  dtoi_accum u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .class_i  (cls),
    .last_i   (in_last_q),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_code_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    if (res_load) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_res_q.value;
  assign m_axis_tuser_o  = out_res_q.status;

  // error results carry a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o != ST_OK)) |-> (m_axis_tdata_o == '0))
    else $error("nonzero value with error status");

  // a result is never overwritten before it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |-> !res_load)
    else $error("result register overwritten while stalled");

  // a word waiting in the input register only stalls when it is a last word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !step) |-> (in_last_q && out_valid_q && !m_axis_tready_i))
    else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

/* test/dtoi_result_checker.sv */
// Checker for decimal_text_to_int32: watches both stream channels, parses the
// character words itself and compares every result word with its own parse.
// Depends on dtoi_pkg.
module dtoi_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [15:0] s_tdata_i,   // [15:0] code_unit
  input  logic        s_tlast_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [31:0] m_tdata_i,   // [31:0] value
  input  logic [1:0]  m_tuser_i,   // [1:0] status
  output int          fail_count_o,
  output int          pending_o,
  output int          results_o
);
  import dtoi_pkg::*;

  result_t     parsed_q[$];
  result_t     want;
  logic [31:0] mag;
  logic        neg;
  logic        first;
  logic        seen;
  logic        bad;
  logic        ovf;

  task automatic clear_number();
    mag   = '0;
    neg   = 1'b0;
    first = 1'b1;
    seen  = 1'b0;
    bad   = 1'b0;
    ovf   = 1'b0;
  endtask

  task automatic queue_result(input result_t res);
    parsed_q.insert(parsed_q.size(), res);
  endtask

  task automatic fold_char(input logic [15:0] code, input logic lst);
    logic [15:0]     d;
    logic [AccW-1:0] limit;
    logic [AccW-1:0] next;
    result_t         res;
    d = code - CH_ZERO;
    if (first && code == CH_MINUS) begin
      neg = 1'b1;
    end else if (d <= 16'd9) begin
      seen = 1'b1;
      if (!ovf) begin
        limit = neg ? NEG_LIMIT : POS_LIMIT;
        next  = AccW'(mag) * 36'd10 + AccW'(d);
        if (next > limit) ovf = 1'b1;
        else mag = next[31:0];
      end
    end else begin
      bad = 1'b1;
    end
    first = 1'b0;
    if (lst) begin
      res.value = '0;
      if (bad) res.status = ST_BAD_CHAR;
      else if (ovf) res.status = ST_OVERFLOW;
      else if (!seen) res.status = ST_NO_DIGITS;
      else begin
        res.status = ST_OK;
        res.value  = neg ? (32'd0 - mag) : mag;
      end
      queue_result(res);
      clear_number();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_number();
      parsed_q.delete();
      pending_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        results_o++;
        if (parsed_q.size() == 0) begin
          $error("unexpected result word: status %0d value %0d",
                 m_tuser_i, $signed(m_tdata_i));
          fail_count_o++;
        end else begin
          want = parsed_q.pop_front();
          if (m_tuser_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tuser_i);
            fail_count_o++;
          end
          if (m_tdata_i !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, $signed(m_tdata_i));
            fail_count_o++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) fold_char(s_tdata_i, s_tlast_i);
      pending_o <= parsed_q.size();
    end
  end

endmodule

/* test/tb_decimal_text_to_int32.sv */
// Testbench top for decimal_text_to_int32: drives number texts with bursts,
// gaps and output stalls, and gives the verdict from dtoi_result_checker.
// Depends on dtoi_pkg, decimal_text_to_int32, dtoi_result_checker.
module tb_decimal_text_to_int32;
  import dtoi_pkg::*;

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        hold_req = 1'b0;

  int          fail_count;
  int          pending;
  int          results;
  int          chars_sent   = 0;
  int          numbers_sent = 0;
  int          burst_left   = 0;
  bit          calm         = 1'b0;
  logic [15:0] text_q[$];

  always #5 clk = ~clk;

  decimal_text_to_int32 dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  dtoi_result_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tlast_i    (s_tlast),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tuser_i    (m_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results)
  );

  task automatic add_code(input logic [15:0] code);
    text_q.insert(text_q.size(), code);
  endtask

  task automatic send_word(input logic [15:0] code, input logic lst);
    int gap;
    if (burst_left == 0) begin
      if (calm) gap = 0;
      else if ($urandom_range(0, 3) == 0) gap = $urandom_range(1, 12);
      else gap = $urandom_range(0, 2);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= code;
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) add_code({8'h00, s[i]});
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_word(text_q[i], i == text_q.size() - 1);
    chars_sent += text_q.size();
    numbers_sent++;
    text_q.delete();
  endtask

  task automatic send_str(input string s);
    push_str(s);
    send_text();
  endtask

  task automatic await_drain();
    int waited;
    waited = 0;
    s_tvalid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending != 0 && waited < 20000);
  endtask

  function automatic longint unsigned pick_magnitude();
    case ($urandom_range(0, 6))
      0: return $urandom_range(0, 9);
      1: return $urandom_range(0, 99999);
      2: return $urandom();
      3: return 64'd2147483640 + $urandom_range(0, 16);
      4: return {$urandom(), $urandom()} % 64'd100000000000;
      5: return {$urandom(), $urandom()};
      default: return $urandom_range(0, 32'h7fffffff);
    endcase
  endfunction

  function automatic logic [15:0] noise_code();
    case ($urandom_range(0, 5))
      0: return CH_MINUS;
      1: return CH_ZERO - 16'd1;
      2: return CH_NINE + 16'd1;
      3: return (CH_ZERO + 16'($urandom_range(0, 9))) | (16'h1 << $urandom_range(6, 15));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic push_number(input bit minus);
    int zeros;
    zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
    if (minus) add_code(CH_MINUS);
    repeat (zeros) add_code(CH_ZERO);
    push_str($sformatf("%0d", pick_magnitude()));
  endtask

  // receiver: stall pattern changes per stretch; one long hold on request
  initial begin
    int  mode;
    int  span;
    int  tick;
    bit  held;
    held = 1'b0;
    tick = 0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 96);
      repeat (span) begin
        @(posedge clk);
        tick++;
        if (hold_req && !held) begin
          m_tready <= 1'b0;
          repeat (300) @(posedge clk);
          held = 1'b1;
        end
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= (tick % 3 == 0);
        endcase
      end
    end
  end

  initial begin
    int r;
    int pos;
    int target;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: range edges, sign rules, bad characters, error precedence
    send_str("0");
    send_str("-0");
    send_str("2147483647");
    send_str("-2147483648");
    send_str("2147483648");
    send_str("-2147483649");
    send_str("0000000000002147483647");
    send_str("-");
    send_str("--5");
    send_str("5-5");
    send_str("12a");
    send_str("+5");
    send_str(" 5");
    send_str("/");
    send_str(":");
    send_str("99999999999999999999");
    send_str("9999999999x");
    send_str("-x");
    add_code(16'hffff);
    send_text();
    add_code(16'h0000);
    send_text();
    push_str("4");
    add_code(CH_ZERO | 16'h8000);
    send_text();
    await_drain();

    // long output stall while short numbers keep coming
    hold_req <= 1'b1;
    calm = 1'b1;
    repeat (30) begin
      add_code(CH_ZERO + 16'($urandom_range(0, 9)));
      send_text();
    end
    calm = 1'b0;
    await_drain();

    target = 1050;
    while (chars_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 64) begin
        push_number($urandom_range(0, 1));
      end else if (r < 84) begin
        push_number($urandom_range(0, 1));
        pos = $urandom_range(0, text_q.size() - 1);
        case ($urandom_range(0, 2))
          0: text_q[pos] = noise_code();
          1: if (text_q.size() > 1) text_q[$urandom_range(1, text_q.size() - 1)] = CH_MINUS;
             else add_code(CH_MINUS);
          default: add_code(noise_code());
        endcase
      end else if (r < 92) begin
        add_code(CH_MINUS);
        if ($urandom_range(0, 1) == 1) add_code(noise_code());
      end else begin
        repeat ($urandom_range(1, 3)) add_code(noise_code());
      end
      send_text();
      if ($urandom_range(0, 29) == 0) calm = !calm;
      if ($urandom_range(0, 39) == 0) await_drain();
    end

    await_drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d characters in %0d numbers; %0d results checked.",
             chars_sent, numbers_sent, results);
    $display("Included range edges, sign and bad-character cases, bursts and a long stall.");
    if (pending != 0) $error("%0d results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("** decimal_text_to_int32: PASSED **");
    end else begin
      $display("** decimal_text_to_int32: FAILED **");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("** decimal_text_to_int32: FAILED **");
    $finish;
  end

endmodule
